FILE: hw/rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg: shared types, constants and the control program
// Digit widths, microcode word layout, reciprocal table and step program for
// the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int MAX_DIGITS = 10;
   localparam int FRAC_W     = 32;
   localparam int WHOLE_W    = 31;
   localparam int DIGIT_W    = 4;
   localparam int BASE_W     = 4;
   localparam int RECIP_W    = 32;
   localparam int PROD_W     = WHOLE_W + RECIP_W;
   localparam int FPROD_W    = FRAC_W + BASE_W;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int PC_W       = 4;

   localparam logic [BASE_W-1:0] BASE_RESET = 4'd2;
   localparam logic [BASE_W-1:0] BASE_MIN   = 4'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 4'd9;

   // step addresses
   localparam logic [PC_W-1:0] STEP_LOAD     = 4'd0;
   localparam logic [PC_W-1:0] STEP_WCHK     = 4'd1;
   localparam logic [PC_W-1:0] STEP_DIV_MUL  = 4'd2;
   localparam logic [PC_W-1:0] STEP_DIV_FIX  = 4'd3;
   localparam logic [PC_W-1:0] STEP_CCHK     = 4'd4;
   localparam logic [PC_W-1:0] STEP_EMIT_W   = 4'd5;
   localparam logic [PC_W-1:0] STEP_FCHK     = 4'd6;
   localparam logic [PC_W-1:0] STEP_EMIT_F   = 4'd7;
   localparam logic [PC_W-1:0] STEP_ECHK     = 4'd8;
   localparam logic [PC_W-1:0] STEP_EMIT_Z   = 4'd9;
   localparam logic [PC_W-1:0] PROG_LEN      = 4'd10;

   typedef enum logic [2:0] {
      OP_NOP        = 3'd0,
      OP_LOAD       = 3'd1,
      OP_DIV_MUL    = 3'd2,
      OP_DIV_FIX    = 3'd3,
      OP_EMIT_WHOLE = 3'd4,
      OP_EMIT_FRAC  = 3'd5,
      OP_EMIT_ZERO  = 3'd6
   } op_type;

   typedef enum logic [3:0] {
      COND_NEVER      = 4'd0,
      COND_ALWAYS     = 4'd1,
      COND_WHOLE_ZERO = 4'd2,
      COND_DIV_MORE   = 4'd3,
      COND_COUNT_ZERO = 4'd4,
      COND_COUNT_MORE = 4'd5,
      COND_FRAC_ZERO  = 4'd6,
      COND_FRAC_MORE  = 4'd7,
      COND_EMITTED    = 4'd8
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   fire;
   } dp_ctrl_type;

   typedef struct packed {
      logic whole_zero;
      logic div_more;
      logic count_zero;
      logic count_more;
      logic frac_zero;
      logic frac_more;
      logic emitted;
      logic slot_free;
   } dp_stat_type;

   // control program, one word per step
   function automatic ucode_type rdc_ucode(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         STEP_LOAD:    w = '{OP_LOAD,       COND_NEVER,      STEP_LOAD};
         STEP_WCHK:    w = '{OP_NOP,        COND_WHOLE_ZERO, STEP_CCHK};
         STEP_DIV_MUL: w = '{OP_DIV_MUL,    COND_NEVER,      STEP_LOAD};
         STEP_DIV_FIX: w = '{OP_DIV_FIX,    COND_DIV_MORE,   STEP_DIV_MUL};
         STEP_CCHK:    w = '{OP_NOP,        COND_COUNT_ZERO, STEP_FCHK};
         STEP_EMIT_W:  w = '{OP_EMIT_WHOLE, COND_COUNT_MORE, STEP_EMIT_W};
         STEP_FCHK:    w = '{OP_NOP,        COND_FRAC_ZERO,  STEP_ECHK};
         STEP_EMIT_F:  w = '{OP_EMIT_FRAC,  COND_FRAC_MORE,  STEP_EMIT_F};
         STEP_ECHK:    w = '{OP_NOP,        COND_EMITTED,    STEP_LOAD};
         STEP_EMIT_Z:  w = '{OP_EMIT_ZERO,  COND_ALWAYS,     STEP_LOAD};
         default:      w = '{OP_NOP,        COND_ALWAYS,     STEP_LOAD};
      endcase
      return w;
   endfunction

   // floor(2^32 / base); quotient estimate is low by at most one
   function automatic logic [RECIP_W-1:0] rdc_recip(input logic [BASE_W-1:0] b);
      logic [RECIP_W-1:0] r;
      case (b)
         4'd3:    r = 32'h5555_5555;
         4'd4:    r = 32'h4000_0000;
         4'd5:    r = 32'h3333_3333;
         4'd6:    r = 32'h2AAA_AAAA;
         4'd7:    r = 32'h2492_4924;
         4'd8:    r = 32'h2000_0000;
         4'd9:    r = 32'h1C71_C71C;
         default: r = 32'h8000_0000;
      endcase
      return r;
   endfunction

   function automatic logic [BASE_W-1:0] rdc_clamp_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (b > BASE_MAX) begin
         r = BASE_MAX;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/rdc_seq.sv
// ----------------------------------------------------------------------------
// rdc_seq: microcode sequencer
// Step counter, program lookup, stall on a busy output slot, conditional jumps.
// ----------------------------------------------------------------------------
module rdc_seq
   import rdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  dp_stat_type stat,
   output dp_ctrl_type ctrl
);

   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       uw;
   logic            needs_slot;
   logic            fire;
   logic            take;

   assign uw = rdc_ucode(pc_ff);

   always_comb begin
      needs_slot = uw.op inside {OP_EMIT_WHOLE, OP_EMIT_FRAC, OP_EMIT_ZERO};
      fire = (!needs_slot || stat.slot_free) && ((uw.op != OP_LOAD) || req_tvalid);
      case (uw.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_WHOLE_ZERO: take = stat.whole_zero;
         COND_DIV_MORE:   take = stat.div_more;
         COND_COUNT_ZERO: take = stat.count_zero;
         COND_COUNT_MORE: take = stat.count_more;
         COND_FRAC_ZERO:  take = stat.frac_zero;
         COND_FRAC_MORE:  take = stat.frac_more;
         COND_EMITTED:    take = stat.emitted;
         default:         take = 1'b1;
      endcase
      // hold on a stall, else jump or advance
      if (!fire) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   assign ctrl.op   = uw.op;
   assign ctrl.fire = fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

`ifndef SYNTHESIS
   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      pc_ff < PROG_LEN)
      else $error("step counter left the program");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(pc_ff))
      else $error("step counter moved during a stall");
`endif

endmodule

FILE: hw/rtl/rdc_dpath.sv
// ----------------------------------------------------------------------------
// rdc_dpath: conversion datapath
// Reciprocal divide, fraction multiply, whole digit store and output register.
// ----------------------------------------------------------------------------
module rdc_dpath
   import rdc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_ctrl_type         ctrl,
   input  logic [BASE_W-1:0]   base,
   input  logic [WHOLE_W-1:0]  in_whole,
   input  logic [FRAC_W-1:0]   in_frac,
   output dp_stat_type         stat,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [DIGIT_W-1:0]  rsp_digit,
   output logic                rsp_is_frac,
   output logic                rsp_last
);

   logic [WHOLE_W-1:0] whole_ff, whole_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   fcnt_ff, fcnt_in;
   logic               emitted_ff, emitted_in;
   logic [DIGIT_W-1:0] store_ff [MAX_DIGITS];
   logic               store_we;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0] rsp_digit_ff, rsp_digit_in;
   logic               rsp_frac_ff, rsp_frac_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [WHOLE_W-1:0] q_est, q_fix;
   logic [8:0]         qb_lo;
   logic [4:0]         r_est, r_fix;
   logic               corr;
   logic [FPROD_W-1:0] fprod;
   logic [CNT_W-1:0]   count_m1;
   logic               slot_free;

   // whole division: estimate, then one correction step
   always_comb begin
      q_est = prod_ff[PROD_W-1:RECIP_W];
      qb_lo = 9'(q_est[4:0]) * 9'(base);
      r_est = whole_ff[4:0] - qb_lo[4:0];
      corr  = (r_est >= {1'b0, base});
      r_fix = corr ? (r_est - {1'b0, base}) : r_est;
      q_fix = q_est + WHOLE_W'(corr);
   end

   assign fprod     = FPROD_W'(frac_ff) * FPROD_W'(base);
   assign count_m1  = count_ff - CNT_W'(1);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.whole_zero = (whole_ff == '0);
      stat.div_more   = (q_fix != '0) && (count_ff != CNT_W'(MAX_DIGITS - 1));
      stat.count_zero = (count_ff == '0);
      stat.count_more = (count_ff > CNT_W'(1));
      stat.frac_zero  = (frac_ff == '0);
      stat.frac_more  = (fprod[FRAC_W-1:0] != '0) && (fcnt_ff != CNT_W'(MAX_DIGITS - 1));
      stat.emitted    = emitted_ff;
      stat.slot_free  = slot_free;
   end

   always_comb begin
      whole_in     = whole_ff;
      frac_in      = frac_ff;
      prod_in      = prod_ff;
      count_in     = count_ff;
      fcnt_in      = fcnt_ff;
      emitted_in   = emitted_ff;
      store_we     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_digit_in = rsp_digit_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctrl.fire) begin
         case (ctrl.op)
            OP_LOAD: begin
               whole_in   = in_whole;
               frac_in    = in_frac;
               count_in   = '0;
               fcnt_in    = '0;
               emitted_in = 1'b0;
            end
            OP_DIV_MUL: begin
               prod_in = PROD_W'(whole_ff) * PROD_W'(rdc_recip(base));
            end
            OP_DIV_FIX: begin
               store_we = 1'b1;
               whole_in = q_fix;
               count_in = count_ff + CNT_W'(1);
            end
            OP_EMIT_WHOLE: begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = store_ff[count_m1[IDX_W-1:0]];
               rsp_frac_in  = 1'b0;
               rsp_last_in  = (count_ff == CNT_W'(1)) && (frac_ff == '0);
               count_in     = count_m1;
               emitted_in   = 1'b1;
            end
            OP_EMIT_FRAC: begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = fprod[FPROD_W-1:FRAC_W];
               rsp_frac_in  = 1'b1;
               rsp_last_in  = !stat.frac_more;
               frac_in      = fprod[FRAC_W-1:0];
               fcnt_in      = fcnt_ff + CNT_W'(1);
               emitted_in   = 1'b1;
            end
            OP_EMIT_ZERO: begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = '0;
               rsp_frac_in  = 1'b0;
               rsp_last_in  = 1'b1;
               emitted_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fcnt_ff      <= '0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         fcnt_ff      <= fcnt_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      whole_ff     <= whole_in;
      frac_ff      <= frac_in;
      prod_ff      <= prod_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_frac_ff  <= rsp_frac_in;
      rsp_last_ff  <= rsp_last_in;
      if (store_we) begin
         store_ff[count_ff[IDX_W-1:0]] <= r_fix[DIGIT_W-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_digit   = rsp_digit_ff;
   assign rsp_is_frac = rsp_frac_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DIGITS) && fcnt_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit counter past the store depth");

   a_rem_below_base: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && ctrl.op == OP_DIV_FIX) |-> (r_fix < {1'b0, base}))
      else $error("corrected remainder not below the base");

   a_emit_from_store: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && ctrl.op == OP_EMIT_WHOLE) |-> (count_ff != '0))
      else $error("whole digit read from an empty store");

   a_frac_digit_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && ctrl.op == OP_EMIT_FRAC) |-> (fprod[FPROD_W-1:FRAC_W] < base))
      else $error("fraction digit not below the base");
`endif

endmodule

FILE: hw/rtl/radix_digit_converter_top.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_top: radix digit converter
// Converts an unsigned whole part and a Q0.32 fraction into base 2..9 digits.
// ----------------------------------------------------------------------------
// Usage:
//  - Write the base on csr_wr_data with csr_wr_en high while the block is idle.
//    Values below 2 act as 2, above 9 act as 9. Reset sets base 2.
//  - Offer one item on req_*: whole part in req_tdata[30:0], fraction in
//    req_tdata[62:31]. The item is taken only at the program's load step.
//  - Digits come out on rsp_*, one item each: whole digits most significant
//    first (at most ten), then fraction digits in the order they arise (at
//    most ten). rsp_tuser marks a fraction digit, rsp_tlast the final digit.
//    A zero input yields a single whole digit 0 with rsp_tlast set.
//  - Work per item: each whole digit costs a reciprocal multiply and a
//    correction step plus one emit; each fraction digit one
//    multiply-and-emit. The first digit shows only once every whole digit
//    has been divided out.
//  - A stalled receiver holds the output register and freezes the step
//    counter on the next emit step; nothing is dropped.
//  - Reset (synchronous) returns the sequencer to its load step and empties
//    the output register.
// ----------------------------------------------------------------------------
module radix_digit_converter_top
   import rdc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic [BASE_W-1:0]   csr_wr_data,   // digit_base
   // input channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [63:0]         req_tdata,     // [30:0] whole_value, [62:31] fraction_value
   // result channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,     // [3:0] digit
   output logic                rsp_tuser,     // [0] is_fraction
   output logic                rsp_tlast      // last_digit
);

   logic [BASE_W-1:0]  base_ff, base_in;
   logic [BASE_W-1:0]  eff_base;
   dp_ctrl_type        ctrl;
   dp_stat_type        stat;
   logic [DIGIT_W-1:0] digit;

   // base register; clamp at the point of use
   assign base_in  = csr_wr_en ? csr_wr_data : base_ff;
   assign eff_base = rdc_clamp_base(base_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   // accept an item only while the program sits at its load step
   assign req_tready = (ctrl.op == OP_LOAD);

   rdc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   rdc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .base        (eff_base),
      .in_whole    (req_tdata[WHOLE_W-1:0]),
      .in_frac     (req_tdata[WHOLE_W+FRAC_W-1:WHOLE_W]),
      .stat        (stat),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_digit   (digit),
      .rsp_is_frac (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   // pad the digit to a whole byte
   assign rsp_tdata = {4'b0000, digit};

`ifndef SYNTHESIS
   a_load_only_idle_out: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !(rsp_tvalid && $rose(rsp_tvalid) && rsp_tuser))
      else $error("fraction digit produced right after an item was taken");

   a_tdata_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:4] == 4'b0000 && rsp_tdata[3:0] < eff_base))
      else $error("output digit out of range");

   a_zero_is_last: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && ctrl.op == OP_EMIT_ZERO) |=> (rsp_tvalid && rsp_tlast && !rsp_tuser))
      else $error("zero result not marked as the final whole digit");
`endif

endmodule

FILE: bench/tb_radix_digit_converter_top.sv
// ----------------------------------------------------------------------------
// tb_radix_digit_converter_top: self-checking bench for the radix converter
// Sends whole/fraction pairs under every base 2..9, predicts the digit
// stream of each item and checks every digit, its fraction flag and the end
// marker as it leaves the block, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter_top
   import rdc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // quiet cycles tolerated before the run is declared hung
   localparam int QUIET_LIMIT = 2000;
   // idle cycles allowed after the last digit has arrived
   localparam int TAIL_CYCLES = 60;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               is_fraction;
      logic               last;
   } digit_item_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [BASE_W-1:0]   csr_wr_data;
   logic                req_tvalid;
   logic                req_tready;
   logic [63:0]         req_tdata;     // [30:0] whole_value, [62:31] fraction_value
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [7:0]          rsp_tdata;     // [3:0] digit
   logic                rsp_tuser;     // [0] is_fraction
   logic                rsp_tlast;     // last_digit

   // base as last written; the block clamps it when it converts
   logic [BASE_W-1:0]   base_setting;
   // digits still owed by the block, oldest first
   digit_item_type      pending_digits[$];
   int                  errors;
   int                  quiet_cycles;
   int                  stall_left;
   // phases with no idling on either channel
   bit                  steady_flow;

   radix_digit_converter_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Pick an idle stretch: mostly none or short, now and then a long one.
   function automatic int pause_length();
      int pick;
      if (steady_flow) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Clamp the written base into 2..9 the way the converter uses it.
   function automatic longint unsigned base_in_use();
      if (base_setting < 2) begin
         return 2;
      end else if (base_setting > 9) begin
         return 9;
      end
      return base_setting;
   endfunction

   // Work out the digit stream for one item and queue it.
   task automatic convert_number(input logic [WHOLE_W-1:0] whole,
                                 input logic [FRAC_W-1:0] frac);
      digit_item_type     fresh[$];
      digit_item_type     item;
      logic [DIGIT_W-1:0] held[MAX_DIGITS];
      longint unsigned    b;
      longint unsigned    w;
      longint unsigned    f;
      longint unsigned    prod;
      int                 count;
      b = base_in_use();
      w = whole;
      f = frac;
      count = 0;
      // divide out whole digits, least significant first; drop any past ten
      while (w != 0 && count < MAX_DIGITS) begin
         held[count] = DIGIT_W'(w % b);
         w = w / b;
         count++;
      end
      // whole digits leave most significant first
      for (int i = count - 1; i >= 0; i--) begin
         item.digit = held[i];
         item.is_fraction = 1'b0;
         item.last = 1'b0;
         fresh.push_back(item);
      end
      // multiply out fraction digits: the carry above the point is the digit
      count = 0;
      while (f != 0 && count < MAX_DIGITS) begin
         prod = f * b;
         item.digit = DIGIT_W'(prod >> FRAC_W);
         item.is_fraction = 1'b1;
         item.last = 1'b0;
         fresh.push_back(item);
         f = prod & 64'hFFFF_FFFF;
         count++;
      end
      // a zero number still yields one whole digit 0
      if (fresh.size() == 0) begin
         item.digit = '0;
         item.is_fraction = 1'b0;
         item.last = 1'b0;
         fresh.push_back(item);
      end
      item = fresh.pop_back();
      item.last = 1'b1;
      fresh.push_back(item);
      foreach (fresh[i]) begin
         pending_digits.push_back(fresh[i]);
      end
   endtask

   // Offer one item after a random gap, hold it until taken, then predict.
   task automatic send_number(input logic [WHOLE_W-1:0] whole,
                              input logic [FRAC_W-1:0] frac);
      int gap;
      gap = pause_length();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, frac, whole};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      convert_number(whole, frac);
   endtask

   // Drop valid, let every owed digit arrive and the block return to load.
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Write the base only once the block has gone idle.
   task automatic write_digit_base(input logic [BASE_W-1:0] value);
      settle_block();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      base_setting = value;
   endtask

   // Zero input, ten-digit limits and fraction endings under the reset base.
   task automatic test_reset_base();
      send_number('0, '0);
      send_number(31'h7FFF_FFFF, '0);
      send_number(31'd1023, '0);
      send_number(31'd1024, '0);
      send_number('0, 32'h8000_0000);
      send_number('0, 32'h0000_0001);
      send_number(31'd1, 32'hFFFF_FFFF);
   endtask

   // Largest fields and a long-running fraction at the top base.
   task automatic test_digit_limits();
      write_digit_base(4'd9);
      send_number(31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_number(31'd8, '0);
      send_number('0, 32'h1C71_C71C);
      send_number(31'd387_420_489, 32'h5555_5555);
      send_number('0, '0);
   endtask

   // Bases outside 2..9 must act as the nearest end of the range.
   task automatic test_base_clamping();
      write_digit_base(4'd0);
      send_number(31'd5, 32'h4000_0000);
      write_digit_base(4'd1);
      send_number(31'd3, 32'hC000_0000);
      write_digit_base(4'd15);
      send_number(31'd80, 32'h5555_5555);
      write_digit_base(4'd10);
      send_number(31'h7FFF_FFFF, 32'h1234_5678);
   endtask

   // Random numbers shaped around digit boundaries, one phase per base.
   task automatic test_random_numbers();
      logic [WHOLE_W-1:0] whole;
      logic [FRAC_W-1:0]  frac;
      longint unsigned    b;
      longint unsigned    span;
      longint unsigned    cube;
      longint unsigned    k;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase < 8) begin
            write_digit_base(BASE_W'(phase + 2));
         end else begin
            write_digit_base(BASE_W'($urandom_range(0, 15)));
         end
         steady_flow = (phase == 3 || phase == 7);
         b = base_in_use();
         // smallest value with more than ten digits, capped at the field
         span = 1;
         repeat (MAX_DIGITS) span = span * b;
         if (span > 64'h7FFF_FFFF) begin
            span = 64'h7FFF_FFFF;
         end
         cube = b * b * b;
         for (int n = 0; n < 40; n++) begin
            case ($urandom_range(0, 5))
               0: begin
                  whole = '0;
               end
               1: begin
                  whole = WHOLE_W'($urandom_range(1, 1000));
               end
               2: begin
                  whole = WHOLE_W'(span - 1 + $urandom_range(0, 2));
               end
               3: begin
                  whole = WHOLE_W'($urandom >> $urandom_range(1, 31));
               end
               default: begin
                  whole = WHOLE_W'($urandom);
               end
            endcase
            case ($urandom_range(0, 5))
               0: begin
                  frac = '0;
               end
               1: begin
                  // only a few top bits: short expansions in power-of-two bases
                  frac = $urandom & ~(32'hFFFF_FFFF >> $urandom_range(1, 8));
               end
               2: begin
                  // close to k / base^3, so the expansion nearly terminates
                  k = 64'($urandom_range(1, 32'(cube - 1)));
                  frac = FRAC_W'((k << FRAC_W) / cube);
               end
               3: begin
                  frac = 32'hFFFF_FFFF;
               end
               default: begin
                  frac = $urandom;
               end
            endcase
            send_number(whole, frac);
         end
      end
      steady_flow = 1'b0;
   endtask

   // Receiver: random stalls, held low for the chosen length.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (steady_flow || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left = pause_length();
      end
   end

   // Check each digit against the oldest prediction; watch for a hang.
   always @(posedge clock) begin
      digit_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digits.size() == 0) begin
            $display("%0t: digit %0d fraction %0b last %0b arrived with none expected",
                     $time, rsp_tdata[DIGIT_W-1:0], rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = pending_digits.pop_front();
            if (rsp_tdata[DIGIT_W-1:0] !== want.digit) begin
               $display("%0t: digit expected %0d actual %0d",
                        $time, want.digit, rsp_tdata[DIGIT_W-1:0]);
               errors++;
            end
            if (rsp_tuser !== want.is_fraction) begin
               $display("%0t: is_fraction expected %0b actual %0b",
                        $time, want.is_fraction, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_digit expected %0b actual %0b",
                        $time, want.last, rsp_tlast);
               errors++;
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      base_setting = BASE_RESET;
      errors       = 0;
      quiet_cycles = 0;
      stall_left   = 0;
      steady_flow  = 1'b0;
      // hold reset, then release it away from the sampling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_base();
      test_digit_limits();
      test_base_clamping();
      test_random_numbers();

      // drain what is still owed, then give stray digits time to show up
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
